// File: rtl/igr_pkg.sv
// Shared types, constants and helpers for the IMU gravity removal integrator.
`timescale 1ns / 1ps
package igr_pkg;

  // Default parameter values
  localparam int ACC_FRAC_BITS_DEF = 16;
  localparam int INTEGRAL_BITS_DEF = 48;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam logic [AXIS_W-1:0] AXIS_FIRST = AXIS_W'(0);
  localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_W'(NUM_AXES - 1);

  // Field widths
  localparam int RAW_W    = 16;
  localparam int DT_W     = 16;
  localparam int OFFSET_W = 13;
  localparam int SCALE_W  = 16;
  localparam int ALPHA_W  = 16;
  localparam int BAND_W   = 20;
  localparam int LIN_W    = 32;
  localparam int SUM_W    = 48;

  // Registers holding Q0.16 weights
  localparam int WEIGHT_FRAC = 16;

  // Shared multiplier: 33-bit signed by 17-bit signed (unsigned zero-extended)
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Trapezoid divide by 2000 on a 48-bit magnitude, 8 quotient bits per cycle
  localparam int DIV_MAG_W   = 48;
  localparam int DIV_BITS    = 8;
  localparam int DIV_STEPS   = DIV_MAG_W / DIV_BITS;
  localparam int DIV_CNT_W   = 3;
  localparam int DIV_REM_W   = 11;
  localparam logic [DIV_REM_W:0] DT_DIVISOR = 12'd2000;
  localparam int INC_W       = 39;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 3'd5;

  localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = -13'sd82;
  localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = 13'sd82;
  localparam logic signed [OFFSET_W-1:0] OFFSET_Z_RST = -13'sd164;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd157;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd58982;
  localparam logic [BAND_W-1:0]  BAND_RST  = 20'd3277;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic [DT_W-1:0]         elapsed_ms;
  } igr_in_t;

  typedef struct packed {
    logic signed [LIN_W-1:0] lin_x;
    logic signed [LIN_W-1:0] lin_y;
    logic signed [LIN_W-1:0] lin_z;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
  } igr_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_ACC,
    OP_GMUL,
    OP_GUPD,
    OP_LIN,
    OP_DMUL,
    OP_DLOAD,
    OP_DIV,
    OP_ACCUM,
    OP_OUT
  } igr_op_e;

  typedef struct packed {
    igr_op_e           op;
    logic [AXIS_W-1:0] axis;
  } igr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } igr_stat_t;

  function automatic logic signed [LIN_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi) begin
      sat32 = hi[LIN_W-1:0];
    end else if (x < lo) begin
      sat32 = lo[LIN_W-1:0];
    end else begin
      sat32 = x[LIN_W-1:0];
    end
  endfunction

endpackage

// File: rtl/igr_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps
interface igr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/igr_ctrl.sv
// Sequencer for the per-axis scale, filter, dead band and integration steps.
`timescale 1ns / 1ps
module igr_ctrl
  import igr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  igr_stat_t stat_i,
  output igr_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SCALE = 11'b000_0000_0010,
    S_ACC   = 11'b000_0000_0100,
    S_GMUL  = 11'b000_0000_1000,
    S_GUPD  = 11'b000_0001_0000,
    S_LIN   = 11'b000_0010_0000,
    S_DMUL  = 11'b000_0100_0000,
    S_DLOAD = 11'b000_1000_0000,
    S_DIV   = 11'b001_0000_0000,
    S_ACCUM = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } igr_state_e;

  igr_state_e        state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cmd_o.op    = OP_NONE;
    cmd_o.axis  = axis_q;
    in_ready_o  = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          axis_d   = AXIS_FIRST;
          state_d  = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.op = OP_GMUL;
        state_d  = S_GUPD;
      end
      S_GUPD: begin
        cmd_o.op = OP_GUPD;
        state_d  = S_LIN;
      end
      S_LIN: begin
        cmd_o.op = OP_LIN;
        state_d  = S_DMUL;
      end
      S_DMUL: begin
        cmd_o.op = OP_DMUL;
        state_d  = S_DLOAD;
      end
      S_DLOAD: begin
        cmd_o.op = OP_DLOAD;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (stat_i.div_last) begin
          state_d = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd_o.op = OP_ACCUM;
        if (axis_q == AXIS_LAST) begin
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + AXIS_W'(1);
          state_d = S_SCALE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= AXIS_FIRST;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

`ifndef ASSERT_OFF
  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !stat_i.div_last) |=> (state_q == S_DIV))
    else $error("divider left before its last step");

  a_last_axis_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCUM && axis_q == AXIS_LAST) |=> (state_q == S_DONE))
    else $error("last axis did not finish the item");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (axis_q <= AXIS_LAST))
    else $error("axis counter out of range");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && stat_i.out_free) |=> (state_q == S_IDLE && in_ready_o))
    else $error("result beat not handed off");
`endif

endmodule

// File: rtl/igr_dp.sv
// Datapath: config registers, filter state, shared multiplier, divider, output register.
`timescale 1ns / 1ps
module igr_dp
  import igr_pkg::*;
#(
  parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF,
  parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  igr_in_t               in_data_i,
  input  igr_cmd_t              cmd_i,
  output igr_stat_t             stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output igr_out_t              out_data_o
);

  localparam int ShL  = (ACC_FRAC_BITS >= WEIGHT_FRAC) ? ACC_FRAC_BITS - WEIGHT_FRAC : 0;
  localparam int ShR  = (ACC_FRAC_BITS < WEIGHT_FRAC) ? WEIGHT_FRAC - ACC_FRAC_BITS : 0;
  localparam int SumW = ((INTEGRAL_BITS > INC_W) ? INTEGRAL_BITS : INC_W) + 1;
  localparam logic signed [SumW-1:0] IMax =
    {{(SumW - INTEGRAL_BITS + 1){1'b0}}, {(INTEGRAL_BITS - 1){1'b1}}};
  localparam logic signed [SumW-1:0] IMin = ~IMax;

  // configuration
  logic signed [OFFSET_W-1:0] off_q [NUM_AXES];
  logic [SCALE_W-1:0]         scale_q;
  logic [ALPHA_W-1:0]         alpha_q;
  logic [BAND_W-1:0]          band_q;

  // per-axis state
  logic                            first_q;
  logic signed [LIN_W-1:0]         grav_q  [NUM_AXES];
  logic signed [LIN_W-1:0]         prev_q  [NUM_AXES];
  logic signed [INTEGRAL_BITS-1:0] integ_q [NUM_AXES];

  // working registers
  logic signed [RAW_W-1:0]   raw_q [NUM_AXES];
  logic [DT_W-1:0]           dt_q;
  logic signed [LIN_W-1:0]   acc_q;
  logic signed [LIN_W-1:0]   lin_q;
  logic signed [MUL_P_W-1:0] prod_q;
  logic [DIV_MAG_W-1:0]      div_mag_q;
  logic [DIV_REM_W-1:0]      div_rem_q;
  logic                      div_neg_q;
  logic [DIV_CNT_W-1:0]      div_cnt_q;
  logic                      out_valid_q;
  igr_out_t                  out_q;

  logic [AXIS_W-1:0]         ax;
  logic signed [16:0]        raw_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [63:0]        scaled;
  logic signed [LIN_W-1:0]   acc_d;
  logic signed [LIN_W-1:0]   grav_d;
  logic signed [LIN_W-1:0]   dif;
  logic signed [MUL_A_W-1:0] dif_w;
  logic [MUL_A_W-1:0]        lin_abs;
  logic signed [LIN_W-1:0]   lin_d;
  logic signed [MUL_P_W-1:0] prod_abs;
  logic [DIV_MAG_W-1:0]      div_mag_d;
  logic [DIV_REM_W-1:0]      div_rem_d;
  logic signed [INC_W-1:0]   inc;
  logic signed [SumW-1:0]    tot;
  logic signed [INTEGRAL_BITS-1:0] integ_d;
  logic signed [63:0]        sum_wide [NUM_AXES];

  assign ax = cmd_i.axis;

  // shared multiplier operand select
  always_comb begin
    raw_sum = 17'(raw_q[ax]) + 17'(off_q[ax]);
    mul_a   = '0;
    mul_b   = '0;
    case (cmd_i.op)
      OP_SCALE: begin
        mul_a = MUL_A_W'(raw_sum);
        mul_b = {1'b0, scale_q};
      end
      OP_GMUL: begin
        mul_a = MUL_A_W'(grav_q[ax]) - MUL_A_W'(acc_q);
        mul_b = {1'b0, alpha_q};
      end
      OP_DMUL: begin
        mul_a = MUL_A_W'(prev_q[ax]) + MUL_A_W'(lin_q);
        mul_b = {1'b0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // scale to the acceleration format
  assign scaled = (64'(prod_q) <<< ShL) >>> ShR;
  assign acc_d  = sat32(scaled);

  // alpha*g + (1-alpha)*acc == acc + alpha*(g - acc), floored
  assign grav_d = first_q ? acc_q : sat32(64'(acc_q) + (64'(prod_q) >>> WEIGHT_FRAC));

  // gravity removal and dead band
  assign dif     = sat32(64'(acc_q) - 64'(grav_q[ax]));
  assign dif_w   = MUL_A_W'(dif);
  assign lin_abs = dif_w[MUL_A_W-1] ? MUL_A_W'(-dif_w) : MUL_A_W'(dif_w);
  assign lin_d   = (lin_abs < MUL_A_W'(band_q)) ? '0 : dif;

  assign prod_abs = prod_q[MUL_P_W-1] ? -prod_q : prod_q;

  // restoring divide by 2000, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIV_REM_W:0]   trial;
    logic [DIV_MAG_W-1:0] mag;
    logic [DIV_REM_W-1:0] rem;
    mag = div_mag_q;
    rem = div_rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem, mag[DIV_MAG_W-1]};
      mag   = {mag[DIV_MAG_W-2:0], 1'b0};
      if (trial >= DT_DIVISOR) begin
        rem    = DIV_REM_W'(trial - DT_DIVISOR);
        mag[0] = 1'b1;
      end else begin
        rem = trial[DIV_REM_W-1:0];
      end
    end
    div_mag_d = mag;
    div_rem_d = rem;
  end

  // quotient magnitude is below 2^38, so it fits the increment width
  assign inc = div_neg_q ? -$signed({1'b0, div_mag_q[INC_W-2:0]})
                         : $signed({1'b0, div_mag_q[INC_W-2:0]});
  assign tot = SumW'(integ_q[ax]) + SumW'(inc);

  always_comb begin
    if (tot > IMax) begin
      integ_d = IMax[INTEGRAL_BITS-1:0];
    end else if (tot < IMin) begin
      integ_d = IMin[INTEGRAL_BITS-1:0];
    end else begin
      integ_d = tot[INTEGRAL_BITS-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sum_wide[i] = 64'(integ_q[i]);
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0]    <= OFFSET_X_RST;
      off_q[1]    <= OFFSET_Y_RST;
      off_q[2]    <= OFFSET_Z_RST;
      scale_q     <= SCALE_RST;
      alpha_q     <= ALPHA_RST;
      band_q      <= BAND_RST;
      first_q     <= 1'b1;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        grav_q[i]  <= '0;
        prev_q[i]  <= '0;
        integ_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFFSET_X:     off_q[0] <= cfg_data_i[OFFSET_W-1:0];
          CFG_OFFSET_Y:     off_q[1] <= cfg_data_i[OFFSET_W-1:0];
          CFG_OFFSET_Z:     off_q[2] <= cfg_data_i[OFFSET_W-1:0];
          CFG_ACCEL_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
          CFG_FILTER_ALPHA: alpha_q  <= cfg_data_i[ALPHA_W-1:0];
          CFG_DEAD_BAND:    band_q   <= cfg_data_i[BAND_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_GUPD:  grav_q[ax] <= grav_d;
        OP_DLOAD: div_cnt_q  <= '0;
        OP_DIV:   div_cnt_q  <= div_cnt_q + DIV_CNT_W'(1);
        OP_ACCUM: begin
          integ_q[ax] <= integ_d;
          prev_q[ax]  <= lin_q;
        end
        OP_OUT:   first_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        raw_q[0] <= in_data_i.raw_x;
        raw_q[1] <= in_data_i.raw_y;
        raw_q[2] <= in_data_i.raw_z;
        dt_q     <= in_data_i.elapsed_ms;
      end
      OP_SCALE, OP_GMUL, OP_DMUL: prod_q <= mul_p;
      OP_ACC:   acc_q <= acc_d;
      OP_LIN:   lin_q <= lin_d;
      OP_DLOAD: begin
        div_neg_q <= prod_q[MUL_P_W-1];
        div_mag_q <= prod_abs[DIV_MAG_W-1:0];
        div_rem_q <= '0;
      end
      OP_DIV: begin
        div_mag_q <= div_mag_d;
        div_rem_q <= div_rem_d;
      end
      OP_OUT: begin
        out_q.lin_x <= prev_q[0];
        out_q.lin_y <= prev_q[1];
        out_q.lin_z <= prev_q[2];
        out_q.sum_x <= sum_wide[0][SUM_W-1:0];
        out_q.sum_y <= sum_wide[1][SUM_W-1:0];
        out_q.sum_z <= sum_wide[2][SUM_W-1:0];
      end
      default: ;
    endcase
  end

  assign stat_o.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// File: rtl/imu_gravity_removal_integrator.sv
// Top level: accelerometer gravity removal with saturating trapezoidal integration.
//
//   channel | dir | payload                              | beat
//   in_if   | in  | raw_x, raw_y, raw_z, elapsed_ms      | one sample
//   out_if  | out | lin_x/y/z, sum_x/y/z                 | one result per sample
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i      | one register write
//
// An input beat is accepted in the idle state. The three axes then go in turn through
// the shared 33x17 multiplier (scale, filter, step) and a divide by 2000 that retires
// 8 quotient bits per cycle, and a final step loads the result register. A new beat
// is accepted only after the previous result has been loaded into the result register.
// A stalled result stalls the core only once the next result is ready behind it.
// Reset (async, active low) restores register defaults and clears filter and sums.
`timescale 1ns / 1ps
module imu_gravity_removal_integrator
  import igr_pkg::*;
#(
  parameter int ACC_FRAC_BITS = ACC_FRAC_BITS_DEF,
  parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  igr_stream_if.sink            in_if,
  igr_stream_if.source          out_if
);

  igr_cmd_t  cmd;
  igr_stat_t stat;
  logic      in_ready;
  logic      out_valid;
  igr_out_t  out_data;
  igr_in_t   in_data;

  assign in_data      = in_if.data;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

  igr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  igr_dp #(
    .ACC_FRAC_BITS (ACC_FRAC_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

endmodule

// File: dv/imu_gravity_removal_integrator_tb.sv
// Self-checking testbench for the IMU gravity removal integrator.
`timescale 1ns / 1ps
module imu_gravity_removal_integrator_tb
  import igr_pkg::*;
;

  localparam logic signed [RAW_W-1:0]    RAW_MAX  = 16'sh7FFF;
  localparam logic signed [RAW_W-1:0]    RAW_MIN  = 16'sh8000;
  localparam logic signed [OFFSET_W-1:0] OFS_MAX  = 13'sh0FFF;
  localparam logic signed [OFFSET_W-1:0] OFS_MIN  = 13'sh1000;
  localparam logic [SCALE_W-1:0]         WGT_MAX  = 16'hFFFF;
  localparam logic [BAND_W-1:0]          BAND_MAX = 20'hFFFFF;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;
  localparam int PIPE_LATENCY = 44;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  igr_stream_if #(.T(igr_in_t))  sample_ch ();
  igr_stream_if #(.T(igr_out_t)) motion_ch ();

  imu_gravity_removal_integrator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (sample_ch),
    .out_if     (motion_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Register shadow and filter/integrator state of the predictor
  logic signed [OFFSET_W-1:0] offset_cfg [NUM_AXES] = '{OFFSET_X_RST, OFFSET_Y_RST, OFFSET_Z_RST};
  logic [SCALE_W-1:0] scale_cfg = SCALE_RST;
  logic [ALPHA_W-1:0] alpha_cfg = ALPHA_RST;
  logic [BAND_W-1:0]  band_cfg  = BAND_RST;
  bit     seed_gravity = 1'b1;
  longint gravity_q16  [NUM_AXES] = '{default: 0};
  longint prev_lin_q16 [NUM_AXES] = '{default: 0};
  longint velocity_q16 [NUM_AXES] = '{default: 0};

  igr_out_t predicted_results [$];
  int mismatch_count = 0;
  bit stall_enable = 1'b1;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic igr_out_t predict_motion(input igr_in_t beat);
    igr_out_t res;
    longint raw [NUM_AXES];
    longint lin [NUM_AXES];
    longint acc;
    longint mag;
    longint inc;
    longint total;
    raw[0] = longint'($signed(beat.raw_x));
    raw[1] = longint'($signed(beat.raw_y));
    raw[2] = longint'($signed(beat.raw_z));
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = clip32((raw[a] + longint'(offset_cfg[a])) * longint'(scale_cfg));
      if (seed_gravity) begin
        gravity_q16[a] = acc;
      end else begin
        gravity_q16[a] = clip32((longint'(alpha_cfg) * gravity_q16[a]
                                 + (64'sd65536 - longint'(alpha_cfg)) * acc) >>> 16);
      end
      lin[a] = clip32(acc - gravity_q16[a]);
      mag = (lin[a] < 0) ? -lin[a] : lin[a];
      if (mag < longint'(band_cfg)) lin[a] = 0;
      // trapezoid step, truncated toward zero
      inc = (prev_lin_q16[a] + lin[a]) * longint'(beat.elapsed_ms) / 64'sd2000;
      total = velocity_q16[a] + inc;
      if (total > SUM_MAX) begin
        total = SUM_MAX;
      end else if (total < SUM_MIN) begin
        total = SUM_MIN;
      end
      velocity_q16[a] = total;
      prev_lin_q16[a] = lin[a];
    end
    seed_gravity = 1'b0;
    res.lin_x = lin[0][LIN_W-1:0];
    res.lin_y = lin[1][LIN_W-1:0];
    res.lin_z = lin[2][LIN_W-1:0];
    res.sum_x = velocity_q16[0][SUM_W-1:0];
    res.sum_y = velocity_q16[1][SUM_W-1:0];
    res.sum_z = velocity_q16[2][SUM_W-1:0];
    return res;
  endfunction

  function automatic int draw_gap();
    return stall_enable ? int'($urandom_range(0, 10)) : 0;
  endfunction

  function automatic logic signed [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return RAW_W'($urandom);
      1: return $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
      default: return RAW_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_elapsed();
    case ($urandom_range(0, 4))
      0: return DT_W'($urandom);
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return DT_W'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic send_sample(input logic signed [RAW_W-1:0] x, input logic signed [RAW_W-1:0] y,
                             input logic signed [RAW_W-1:0] z, input logic [DT_W-1:0] dt);
    igr_in_t beat;
    int gap;
    beat.raw_x = x;
    beat.raw_y = y;
    beat.raw_z = z;
    beat.elapsed_ms = dt;
    gap = draw_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= beat;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    predicted_results.push_back(predict_motion(beat));
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic signed [OFFSET_W-1:0] ox,
                              input logic signed [OFFSET_W-1:0] oy,
                              input logic signed [OFFSET_W-1:0] oz,
                              input logic [SCALE_W-1:0] sc, input logic [ALPHA_W-1:0] al,
                              input logic [BAND_W-1:0] bd);
    wait_for_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OFFSET_X;
    cfg_data_i <= CFG_DATA_W'(ox);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OFFSET_Y;
    cfg_data_i <= CFG_DATA_W'(oy);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OFFSET_Z;
    cfg_data_i <= CFG_DATA_W'(oz);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ACCEL_SCALE;
    cfg_data_i <= CFG_DATA_W'(sc);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FILTER_ALPHA;
    cfg_data_i <= CFG_DATA_W'(al);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DEAD_BAND;
    cfg_data_i <= bd;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    offset_cfg[0] = ox;
    offset_cfg[1] = oy;
    offset_cfg[2] = oz;
    scale_cfg = sc;
    alpha_cfg = al;
    band_cfg  = bd;
  endtask

  task automatic program_random_regs();
    logic signed [OFFSET_W-1:0] offs [NUM_AXES];
    logic [SCALE_W-1:0] sc;
    logic [ALPHA_W-1:0] al;
    logic [BAND_W-1:0]  bd;
    for (int a = 0; a < NUM_AXES; a++) begin
      if ($urandom_range(0, 5) == 0) begin
        offs[a] = $urandom_range(0, 1) ? OFS_MAX : OFS_MIN;
      end else begin
        offs[a] = OFFSET_W'($urandom);
      end
    end
    case ($urandom_range(0, 3))
      0: sc = SCALE_W'($urandom);
      1: sc = $urandom_range(0, 1) ? WGT_MAX : '0;
      default: sc = SCALE_W'($urandom_range(100, 400));
    endcase
    case ($urandom_range(0, 3))
      0: al = ALPHA_W'($urandom);
      1: al = $urandom_range(0, 1) ? WGT_MAX : '0;
      default: al = ALPHA_W'($urandom_range(55000, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: bd = BAND_W'($urandom);
      1: bd = $urandom_range(0, 1) ? BAND_MAX : '0;
      default: bd = BAND_W'($urandom_range(0, 65536));
    endcase
    program_regs(offs[0], offs[1], offs[2], sc, al, bd);
  endtask

  // Reset defaults: the first sample seeds gravity, later ones are filtered
  task automatic test_first_sample();
    send_sample(RAW_MAX, RAW_MIN, 16'sd0, 16'hFFFF);
    send_sample(RAW_MIN, RAW_MAX, -16'sd1, 16'hFFFF);
    send_sample(16'sd100, -16'sd100, 16'sd4096, 16'd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'd1);
    send_sample(16'sd2, -16'sd2, 16'sd4100, 16'd1000);
    send_sample(16'sd1, -16'sd1, 16'sd0, 16'd2000);
  endtask

  task automatic test_register_extremes();
    // alpha 0: gravity tracks the sample, scaled values clip at both rails
    program_regs(OFS_MAX, OFS_MIN, OFS_MAX, WGT_MAX, '0, '0);
    send_sample(RAW_MAX, RAW_MIN, 16'sd0, 16'd1000);
    send_sample(RAW_MAX, RAW_MIN, -16'sd1, 16'hFFFF);
    // near-full retention (alpha at its maximum): flipping the rails clips the difference too
    program_regs(OFS_MIN, OFS_MAX, OFS_MIN, WGT_MAX, WGT_MAX, BAND_MAX);
    send_sample(RAW_MIN, RAW_MAX, 16'sd5, 16'hFFFF);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'd0);
    program_regs('0, '0, '0, '0, 16'd32768, 20'd1);
    send_sample(RAW_MAX, RAW_MIN, RAW_MAX, 16'hFFFF);
    send_sample(16'sd1, -16'sd1, 16'sd0, 16'd2000);
    program_regs(OFFSET_X_RST, OFFSET_Y_RST, OFFSET_Z_RST, SCALE_RST, ALPHA_RST, BAND_RST);
    send_sample(16'sd300, -16'sd300, 16'sd4000, 16'd100);
    send_sample(RAW_MIN, RAW_MAX, RAW_MIN, 16'd1);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      program_random_regs();
      stall_enable = (phase % 3 != 2);
      repeat (70) send_sample(rand_raw(), rand_raw(), rand_raw(), rand_elapsed());
    end
    stall_enable = 1'b1;
  endtask

  // Hold x and y differences on the rails so the sums take the largest steps, then reverse
  task automatic test_integral_ramp();
    stall_enable = 1'b0;
    program_regs('0, '0, '0, WGT_MAX, '0, '0);
    send_sample(RAW_MAX, RAW_MIN, 16'sd0, 16'd0);
    program_regs('0, '0, '0, WGT_MAX, WGT_MAX, '0);
    repeat (85) send_sample(RAW_MIN, RAW_MAX, rand_raw(), 16'hFFFF);
    program_regs('0, '0, '0, WGT_MAX, '0, '0);
    send_sample(RAW_MIN, RAW_MAX, 16'sd0, 16'd0);
    program_regs('0, '0, '0, WGT_MAX, WGT_MAX, '0);
    repeat (85) send_sample(RAW_MAX, RAW_MIN, rand_raw(), 16'hFFFF);
    stall_enable = 1'b1;
  endtask

  initial begin : run_tests
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_OFFSET_X;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample();
    test_register_extremes();
    test_random_traffic();
    test_integral_ramp();
    sample_ch.valid <= 1'b0;
    for (int n = 0; n < 20 * PIPE_LATENCY && predicted_results.size() != 0; n++) begin
      @(posedge clk_i);
    end
    repeat (2 * PIPE_LATENCY) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result sink: random stall before taking each beat
  initial begin : result_sink
    int stall;
    motion_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        motion_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      motion_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!motion_ch.valid) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    igr_out_t want;
    if (rst_ni && motion_ch.valid && motion_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result beat with nothing expected");
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("lin_x", $signed(want.lin_x), $signed(motion_ch.data.lin_x));
        check_field("lin_y", $signed(want.lin_y), $signed(motion_ch.data.lin_y));
        check_field("lin_z", $signed(want.lin_z), $signed(motion_ch.data.lin_z));
        check_field("sum_x", $signed(want.sum_x), $signed(motion_ch.data.sum_x));
        check_field("sum_y", $signed(want.sum_y), $signed(motion_ch.data.sum_y));
        check_field("sum_z", $signed(want.sum_z), $signed(motion_ch.data.sum_z));
      end
    end
  end

  initial begin : watchdog
    #(1_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
